>>> rtl/core/xxtea_pkg.sv
`timescale 1ns / 1ps
package xxtea_pkg;

  localparam logic [31:0] TEA_DELTA   = 32'h9E37_79B9;
  localparam int unsigned BASE_ROUNDS = 6;
  localparam int unsigned ROUND_W     = 9;   // 6 + 26 + 255 fits in 9 bits
  localparam int unsigned NCOUNT_W    = 7;   // word count up to 64
  localparam int unsigned PC_W        = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KSHIFT = 3'd5;

  typedef logic [PC_W-1:0] pc_t;

  // Datapath operation selected by each microword
  typedef enum logic [3:0] {
    OP_COLLECT,
    OP_ROUNDS,
    OP_SUM,
    OP_LDH,
    OP_ROUND,
    OP_RDO,
    OP_RDC,
    OP_MIX,
    OP_UPD,
    OP_REND,
    OP_ORD,
    OP_OPUT,
    OP_NOP
  } op_t;

  // Sequencing condition of each microword
  typedef enum logic [2:0] {
    C_SEQ,
    C_GOTO,
    C_SHORT,
    C_MORE_WORDS,
    C_MORE_ROUNDS,
    C_IN_LAST,
    C_OUT_SLOT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic in_last_xfer;
    logic short_msg;
    logic more_words;
    logic more_rounds;
    logic slot_free;
    logic out_final;
  } flags_t;

  localparam pc_t PC_IDLE  = 4'd0;
  localparam pc_t PC_INIT  = 4'd1;
  localparam pc_t PC_SUM   = 4'd2;
  localparam pc_t PC_LDH   = 4'd3;
  localparam pc_t PC_ROUND = 4'd4;
  localparam pc_t PC_RDO   = 4'd5;
  localparam pc_t PC_RDC   = 4'd6;
  localparam pc_t PC_MIX   = 4'd7;
  localparam pc_t PC_UPD   = 4'd8;
  localparam pc_t PC_REND  = 4'd9;
  localparam pc_t PC_ORD   = 4'd10;
  localparam pc_t PC_OPUT  = 4'd11;
  localparam pc_t PC_DONE  = 4'd12;

  // Microprogram ROM
  function automatic uword_t ucode_rom(pc_t pc);
    uword_t uw;
    case (pc)
      PC_IDLE:  uw = '{OP_COLLECT, C_IN_LAST,     PC_INIT};
      PC_INIT:  uw = '{OP_ROUNDS,  C_SHORT,       PC_ORD};
      PC_SUM:   uw = '{OP_SUM,     C_SEQ,         PC_IDLE};
      PC_LDH:   uw = '{OP_LDH,     C_SEQ,         PC_IDLE};
      PC_ROUND: uw = '{OP_ROUND,   C_SEQ,         PC_IDLE};
      PC_RDO:   uw = '{OP_RDO,     C_SEQ,         PC_IDLE};
      PC_RDC:   uw = '{OP_RDC,     C_SEQ,         PC_IDLE};
      PC_MIX:   uw = '{OP_MIX,     C_SEQ,         PC_IDLE};
      PC_UPD:   uw = '{OP_UPD,     C_MORE_WORDS,  PC_RDO};
      PC_REND:  uw = '{OP_REND,    C_MORE_ROUNDS, PC_ROUND};
      PC_ORD:   uw = '{OP_ORD,     C_SEQ,         PC_IDLE};
      PC_OPUT:  uw = '{OP_OPUT,    C_OUT_SLOT,    PC_ORD};
      PC_DONE:  uw = '{OP_NOP,     C_GOTO,        PC_IDLE};
      default:  uw = '{OP_NOP,     C_GOTO,        PC_IDLE};
    endcase
    return uw;
  endfunction

  // 52 / n for n of two and up
  function automatic logic [4:0] div52(logic [NCOUNT_W-1:0] n);
    logic [4:0] q;
    if (n >= 7'd53)      q = 5'd0;
    else if (n >= 7'd27) q = 5'd1;
    else if (n >= 7'd18) q = 5'd2;
    else if (n >= 7'd14) q = 5'd3;
    else if (n >= 7'd11) q = 5'd4;
    else if (n >= 7'd9)  q = 5'd5;
    else if (n == 7'd8)  q = 5'd6;
    else if (n == 7'd7)  q = 5'd7;
    else if (n == 7'd6)  q = 5'd8;
    else if (n == 7'd5)  q = 5'd10;
    else if (n == 7'd4)  q = 5'd13;
    else if (n == 7'd3)  q = 5'd17;
    else                 q = 5'd26;
    return q;
  endfunction

endpackage

>>> rtl/core/xxtea_useq.sv
`timescale 1ns / 1ps
module xxtea_useq import xxtea_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output op_t    op
);

  pc_t    pc_r;
  pc_t    pc_nxt;
  pc_t    pc_inc;
  uword_t uw;

  assign uw     = ucode_rom(pc_r);
  assign pc_inc = pc_r + PC_W'(1);
  assign op     = uw.op;

  always_comb begin
    pc_nxt = pc_inc;
    case (uw.cond)
      C_SEQ:         pc_nxt = pc_inc;
      C_GOTO:        pc_nxt = uw.target;
      C_SHORT:       pc_nxt = flags.short_msg ? uw.target : pc_inc;
      C_MORE_WORDS:  pc_nxt = flags.more_words ? uw.target : pc_inc;
      C_MORE_ROUNDS: pc_nxt = flags.more_rounds ? uw.target : pc_inc;
      // hold until the last word transfers
      C_IN_LAST:     pc_nxt = flags.in_last_xfer ? uw.target : pc_r;
      // hold until the output register frees up
      C_OUT_SLOT: begin
        if (!flags.slot_free)     pc_nxt = pc_r;
        else if (flags.out_final) pc_nxt = pc_inc;
        else                      pc_nxt = uw.target;
      end
      default:       pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> rtl/core/xxtea_block_cipher.sv
`timescale 1ns / 1ps
// Collect: one input word per cycle while collecting; no word is taken in other steps.
// Cipher after the last word: R = 6 + 52/n + round_bias rounds, each made of one word
// update per four microcode steps over a single-port word store.
// Output: each word is read, then loaded into the free output slot, and a closing step
// ends the run; a one-word message skips the cipher. One message is handled at a time.
// Synchronous active-low reset clears the sequencer, word count and flags; no clearing pass.
module xxtea_block_cipher import xxtea_pkg::*; #(
  parameter int MAX_WORDS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [31:0]           in_data_word,
  input  logic                  in_is_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_result_word,
  output logic                  out_result_last,
  output logic                  out_overflowed
);

  localparam int AW = $clog2(MAX_WORDS);
  localparam int CW = $clog2(MAX_WORDS + 1);

  op_t    op;
  flags_t flags;

  logic [31:0]        key_r [4];
  logic [7:0]         bias_r;
  logic [4:0]         kshift_r;

  logic [CW-1:0]      cnt_r;
  logic               mode_r;
  logic               ovf_r;
  logic [AW-1:0]      p_r;
  logic [AW-1:0]      k_r;
  logic [ROUND_W-1:0] rnd_r;
  logic [31:0]        sum_r;
  logic [31:0]        h_r;
  logic [31:0]        o_r;
  logic [31:0]        a_r;
  logic [31:0]        b_r;
  logic [1:0]         kidx_r;

  logic               out_valid_r;
  logic [31:0]        out_word_r;
  logic               out_last_r;
  logic               out_ovf_r;

  logic [31:0]        mem [MAX_WORDS];
  logic [31:0]        rd_data_r;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic [31:0]        mem_wdata;

  logic               in_xfer;
  logic               slot_free;
  logic [CW-1:0]      cnt_m1;
  logic [AW-1:0]      last_idx;
  logic [AW-1:0]      other_idx;
  logic [ROUND_W-1:0] rnd_calc;
  logic [31:0]        sum_prod;
  logic [31:0]        sum_sh;
  logic [31:0]        y_v;
  logic [31:0]        z_v;
  logic [31:0]        mix_a;
  logic [31:0]        mix_b;
  logic [31:0]        mix_t;
  logic [31:0]        upd;

  xxtea_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op)
  );

  assign in_ready  = (op == OP_COLLECT);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign cnt_m1    = cnt_r - CW'(1);
  assign last_idx  = cnt_m1[AW-1:0];

  assign flags.in_last_xfer = in_xfer && in_is_last;
  assign flags.short_msg    = (cnt_r < CW'(2));
  assign flags.more_words   = mode_r ? (p_r != '0) : (p_r != last_idx);
  assign flags.more_rounds  = (rnd_r != ROUND_W'(1));
  assign flags.slot_free    = slot_free;
  assign flags.out_final    = (k_r == last_idx);

  assign rnd_calc = ROUND_W'(BASE_ROUNDS) + ROUND_W'(div52(NCOUNT_W'(cnt_r)))
                  + ROUND_W'(bias_r);
  assign sum_prod = 32'(rnd_r) * TEA_DELTA;
  assign sum_sh   = sum_r >> kshift_r;

  // Neighbor word: next one going up, previous one going down, wrapping at the ends
  always_comb begin
    if (mode_r) begin
      other_idx = (p_r == '0) ? last_idx : p_r - AW'(1);
    end else begin
      other_idx = (p_r == last_idx) ? '0 : p_r + AW'(1);
    end
  end

  assign y_v   = mode_r ? h_r : o_r;
  assign z_v   = mode_r ? o_r : h_r;
  assign mix_a = ((z_v >> 5) ^ (y_v << 2)) + ((y_v >> 3) ^ (z_v << 4));
  assign mix_b = (sum_r ^ y_v) + (key_r[kidx_r] ^ z_v);
  assign mix_t = a_r ^ b_r;
  assign upd   = mode_r ? rd_data_r - mix_t : rd_data_r + mix_t;

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = p_r;
    mem_raddr = p_r;
    mem_wdata = upd;
    case (op)
      OP_COLLECT: begin
        mem_we    = in_xfer && (cnt_r < CW'(MAX_WORDS));
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = in_data_word;
      end
      OP_SUM: begin
        mem_re    = 1'b1;
        mem_raddr = mode_r ? '0 : last_idx;
      end
      OP_RDO: begin
        mem_re    = 1'b1;
        mem_raddr = other_idx;
      end
      OP_RDC: begin
        mem_re    = 1'b1;
        mem_raddr = p_r;
      end
      OP_UPD: begin
        mem_we    = 1'b1;
      end
      OP_ORD: begin
        mem_re    = 1'b1;
        mem_raddr = k_r;
      end
      default: begin
        mem_we    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0]    <= '0;
      key_r[1]    <= '0;
      key_r[2]    <= '0;
      key_r[3]    <= '0;
      bias_r      <= '0;
      kshift_r    <= 5'd2;
      cnt_r       <= '0;
      mode_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY0:   key_r[0] <= cfg_data;
          CFG_KEY1:   key_r[1] <= cfg_data;
          CFG_KEY2:   key_r[2] <= cfg_data;
          CFG_KEY3:   key_r[3] <= cfg_data;
          CFG_BIAS:   bias_r   <= cfg_data[7:0];
          CFG_KSHIFT: kshift_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      // the output step reloads the slot itself
      if (out_valid_r && out_ready && op != OP_OPUT) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        OP_COLLECT: begin
          if (in_xfer) begin
            if (cnt_r == '0) begin
              mode_r <= in_mode;
            end
            if (cnt_r < CW'(MAX_WORDS)) begin
              cnt_r <= cnt_r + CW'(1);
            end else begin
              ovf_r <= 1'b1;  // drop the word
            end
          end
        end
        OP_OPUT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            if (flags.out_final) begin
              cnt_r  <= '0;
              mode_r <= 1'b0;
              ovf_r  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (op)
      OP_COLLECT: k_r <= '0;
      OP_ROUNDS:  rnd_r <= rnd_calc;
      OP_SUM:     sum_r <= mode_r ? sum_prod : '0;
      OP_LDH:     h_r <= rd_data_r;
      OP_ROUND: begin
        if (!mode_r) begin
          sum_r <= sum_r + TEA_DELTA;
        end
        p_r <= mode_r ? last_idx : '0;
      end
      OP_RDO:     kidx_r <= 2'(p_r) ^ sum_sh[1:0];
      OP_RDC:     o_r <= rd_data_r;
      OP_MIX: begin
        a_r <= mix_a;
        b_r <= mix_b;
      end
      OP_UPD: begin
        h_r <= upd;
        p_r <= mode_r ? p_r - AW'(1) : p_r + AW'(1);
      end
      OP_REND: begin
        if (mode_r) begin
          sum_r <= sum_r - TEA_DELTA;
        end
        rnd_r <= rnd_r - ROUND_W'(1);
      end
      OP_OPUT: begin
        if (slot_free) begin
          out_word_r <= rd_data_r;
          out_last_r <= flags.out_final;
          out_ovf_r  <= ovf_r;
          k_r        <= k_r + AW'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_result_word = out_word_r;
  assign out_result_last = out_last_r;
  assign out_overflowed  = out_ovf_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_WORDS))
    else $error("word count beyond store depth");

  a_upd_index: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_UPD) |-> (CW'(p_r) < cnt_r))
    else $error("word update outside the message");

  a_round_left: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_REND) |-> (rnd_r != '0))
    else $error("round counter underflow");

  a_run_close: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_OPUT && slot_free && flags.out_final) |=> (cnt_r == '0 && !ovf_r))
    else $error("run state not cleared after final word");

endmodule

>>> dv/xxtea_block_cipher_test.sv
`timescale 1ns / 1ps
module xxtea_block_cipher_test;
  import xxtea_pkg::*;

  localparam int unsigned MAX_WORDS     = 64;
  localparam int unsigned RANDOM_ITEMS  = 16;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        ovf;
  } out_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_mode;
  logic [31:0]           in_data_word;
  logic                  in_is_last;
  logic                  out_valid;
  logic                  out_ready;
  logic [31:0]           out_result_word;
  logic                  out_result_last;
  logic                  out_overflowed;

  // Shadow of the cipher state
  logic [31:0] cipher_key [4] = '{default: '0};
  logic [7:0]  extra_rounds = '0;
  logic [4:0]  sel_shift = 5'd2;
  logic [31:0] held_words [MAX_WORDS];
  int unsigned held_count = 0;
  logic        held_mode = 1'b0;
  logic        dropped_flag = 1'b0;

  out_word_t   expected_words [$];
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  bit          sender_idle_on = 1'b1;
  bit          receiver_idle_on = 1'b1;
  bit          hold_off = 1'b0;
  bit          result_taken = 1'b0;

  xxtea_block_cipher #(
    .MAX_WORDS(MAX_WORDS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_data_word   (in_data_word),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_word(out_result_word),
    .out_result_last(out_result_last),
    .out_overflowed (out_overflowed)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [31:0] mix_term(logic [31:0] y, logic [31:0] z, logic [31:0] s,
                                           logic [1:0] kidx);
    return (((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4))) ^
           ((s ^ y) + (cipher_key[kidx] ^ z));
  endfunction

  function automatic void encrypt_held(int unsigned n);
    int unsigned rounds;
    int unsigned r;
    int unsigned p;
    logic [31:0] s;
    logic [31:0] z;
    logic [31:0] shifted;
    logic [1:0]  e;
    rounds = 6 + 52 / n + extra_rounds;
    s = '0;
    z = held_words[n-1];
    for (r = 0; r < rounds; r++) begin
      s += TEA_DELTA;
      shifted = s >> sel_shift;
      e = shifted[1:0];
      for (p = 0; p < n - 1; p++) begin
        held_words[p] += mix_term(held_words[p+1], z, s, p[1:0] ^ e);
        z = held_words[p];
      end
      p = n - 1;
      held_words[p] += mix_term(held_words[0], z, s, p[1:0] ^ e);
      z = held_words[p];
    end
  endfunction

  function automatic void decrypt_held(int unsigned n);
    int unsigned rounds;
    int unsigned r;
    int unsigned p;
    logic [31:0] s;
    logic [31:0] y;
    logic [31:0] shifted;
    logic [1:0]  e;
    rounds = 6 + 52 / n + extra_rounds;
    s = rounds * TEA_DELTA;
    y = held_words[0];
    for (r = 0; r < rounds; r++) begin
      shifted = s >> sel_shift;
      e = shifted[1:0];
      for (p = n - 1; p > 0; p--) begin
        held_words[p] -= mix_term(y, held_words[p-1], s, p[1:0] ^ e);
        y = held_words[p];
      end
      held_words[0] -= mix_term(y, held_words[n-1], s, e);
      y = held_words[0];
      s -= TEA_DELTA;
    end
  endfunction

  // Store one accepted word; on the last one, cipher a run of two or more and queue the whole run
  function automatic void absorb_word(logic mode, logic [31:0] word, logic last);
    out_word_t item;
    if (held_count == 0) held_mode = mode;
    if (held_count < MAX_WORDS) begin
      held_words[held_count] = word;
      held_count++;
    end else begin
      dropped_flag = 1'b1;
    end
    if (last) begin
      if (held_count >= 2) begin
        if (held_mode) decrypt_held(held_count);
        else encrypt_held(held_count);
      end
      for (int unsigned k = 0; k < held_count; k++) begin
        item.word = held_words[k];
        item.last = (k == held_count - 1);
        item.ovf  = dropped_flag;
        expected_words.insert(expected_words.size(), item);
      end
      held_count = 0;
      held_mode = 1'b0;
      dropped_flag = 1'b0;
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_KEY0:   cipher_key[0] = value;
      CFG_KEY1:   cipher_key[1] = value;
      CFG_KEY2:   cipher_key[2] = value;
      CFG_KEY3:   cipher_key[3] = value;
      CFG_BIAS:   extra_rounds = value[7:0];
      CFG_KSHIFT: sel_shift = value[4:0];
      default: ;
    endcase
  endtask

  // Unused upper bits carry noise; only the low field must take effect
  task automatic load_config(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                             logic [31:0] k3, logic [7:0] bias, logic [4:0] shift);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(CFG_KEY0, k0);
    write_reg(CFG_KEY1, k1);
    write_reg(CFG_KEY2, k2);
    write_reg(CFG_KEY3, k3);
    write_reg(CFG_BIAS, {junk[31:8], bias});
    write_reg(CFG_KSHIFT, {junk[26:0], shift});
  endtask

  task automatic random_config();
    logic [31:0] k [4];
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 5))
        0:       k[i] = '0;
        1:       k[i] = '1;
        default: k[i] = $urandom;
      endcase
    end
    load_config(k[0], k[1], k[2], k[3], 8'($urandom_range(0, 40)),
                5'($urandom_range(0, 31)));
  endtask

  task automatic send_word(logic mode, logic [31:0] word, logic last);
    int unsigned gap;
    gap = sender_idle_on ? $urandom_range(0, 19) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_data_word <= word;
    in_is_last   <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    absorb_word(mode, word, last);
    words_sent++;
  endtask

  task automatic send_random_message(int unsigned n);
    logic [31:0] word;
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0:       word = '0;
        1:       word = '1;
        default: word = $urandom;
      endcase
      send_word(1'($urandom_range(0, 1)), word, k == n - 1);
    end
  endtask

  // Drop valid, then let every queued word drain before touching config
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic hold_results(int unsigned cycles);
    hold_off = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off = 1'b0;
  endtask

  task automatic test_directed_cases();
    sender_idle_on = 1'b1;
    receiver_idle_on = 1'b1;
    // reset config: zero key, no bias, shift of two
    send_word(1'b0, 32'hFFFF_FFFF, 1'b1);
    send_word(1'b1, 32'h0000_0000, 1'b1);
    send_word(1'b0, 32'h0000_0000, 1'b0);
    send_word(1'b0, 32'hFFFF_FFFF, 1'b1);
    wait_quiet();
    load_config('1, '1, '1, '1, 8'd0, 5'd2);
    send_word(1'b0, 32'hFFFF_FFFF, 1'b0);
    send_word(1'b0, 32'hFFFF_FFFF, 1'b1);
    send_word(1'b1, 32'h0000_0000, 1'b0);
    send_word(1'b1, 32'h0000_0000, 1'b1);
    // mode comes from the first word only
    send_word(1'b1, 32'h8000_0001, 1'b0);
    send_word(1'b0, 32'h7FFF_FFFE, 1'b0);
    send_word(1'b0, 32'h1234_5678, 1'b1);
    wait_quiet();
    load_config($urandom, $urandom, $urandom, $urandom, 8'd255, 5'd31);
    send_word(1'b0, $urandom, 1'b0);
    send_word(1'b1, $urandom, 1'b1);
    wait_quiet();
    load_config($urandom, $urandom, $urandom, $urandom, 8'd255, 5'd0);
    send_word(1'b1, $urandom, 1'b0);
    send_word(1'b0, $urandom, 1'b0);
    send_word(1'b1, $urandom, 1'b1);
  endtask

  task automatic test_store_limits();
    wait_quiet();
    load_config($urandom, $urandom, $urandom, $urandom, 8'd0, 5'($urandom_range(0, 31)));
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b1;
    send_random_message(MAX_WORDS);
    // one word past the store, and that dropped word carries the last marker
    send_random_message(MAX_WORDS + 1);
    send_random_message(2);
  endtask

  task automatic test_output_backpressure();
    wait_quiet();
    load_config($urandom, $urandom, $urandom, $urandom, 8'd0, 5'd2);
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    fork
      hold_results(1200);
      begin
        send_random_message(5);
        send_random_message(5);
        send_random_message(5);
      end
    join
  endtask

  task automatic test_random_messages();
    int unsigned start_count;
    int unsigned phase_items;
    int unsigned len;
    int unsigned pick;
    start_count = words_sent;
    while (words_sent - start_count < RANDOM_ITEMS) begin
      wait_quiet();
      random_config();
      pick = $urandom_range(0, 3);
      sender_idle_on = pick[0];
      receiver_idle_on = pick[1];
      phase_items = 0;
      while (phase_items < 8) begin
        pick = $urandom_range(0, 19);
        if (pick < 3) len = 1;
        else if (pick < 19) len = $urandom_range(2, 8);
        else len = $urandom_range(9, 24);
        send_random_message(len);
        phase_items += len;
      end
    end
  endtask

  // Result side ready: a drawn gap after every transfer when receiver idling is on, or a long hold
  initial begin : result_side
    int unsigned gap;
    gap = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (result_taken) begin
        result_taken = 1'b0;
        gap = receiver_idle_on ? $urandom_range(0, 19) : 0;
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_result
    out_word_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      result_taken = 1'b1;
      if (expected_words.size() == 0) begin
        $error("unexpected result transfer: result_word %h", out_result_word);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_result_word !== want.word) begin
          $error("result_word: expected %h, got %h", want.word, out_result_word);
          fail_count++;
        end
        if (out_result_last !== want.last) begin
          $error("result_last: expected %b, got %b", want.last, out_result_last);
          fail_count++;
        end
        if (out_overflowed !== want.ovf) begin
          $error("overflowed: expected %b, got %b", want.ovf, out_overflowed);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("xxtea_block_cipher_test: done, errors");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_mode      = 1'b0;
    in_data_word = '0;
    in_is_last   = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_store_limits();
    test_output_backpressure();
    test_random_messages();
    wait_quiet();
    if (fail_count == 0) begin
      $display("xxtea_block_cipher_test: done, clean");
    end else begin
      $display("xxtea_block_cipher_test: done, errors");
    end
    $finish;
  end

endmodule
